### rtl/core/mrrm_pkg.sv
// Shared types and constants for the Modbus region register map.
// Holds the sequencer state type, command and address-type codes and the stream field layout.
package mrrm_pkg;

    localparam int DATA_W = 16;

    localparam int CFG_REGS  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [1:0] CMD_RD_BITS = 2'd0;
    localparam logic [1:0] CMD_RD_REGS = 2'd1;
    localparam logic [1:0] CMD_WR_BITS = 2'd2;
    localparam logic [1:0] CMD_WR_REGS = 2'd3;

    localparam logic [1:0] TYPE_COILS    = 2'd0;
    localparam logic [1:0] TYPE_DISCRETE = 2'd1;
    localparam logic [1:0] TYPE_HOLDING  = 2'd2;
    localparam logic [1:0] TYPE_INPUT    = 2'd3;

    localparam int S_TUSER_W  = 4;
    localparam int CMD_LSB    = 0;
    localparam int TYPE_LSB   = 2;
    localparam int S_TDATA_W  = 56;
    localparam int START_LSB  = 0;
    localparam int COUNT_LSB  = 16;
    localparam int COUNT_W    = 11;
    localparam int WIDX_LSB   = 27;
    localparam int WIDX_W     = 6;
    localparam int WDATA_LSB  = 33;
    localparam int SWAP_BIT   = 49;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MATCH,
        ST_BOUND,
        ST_SETUP,
        ST_RD_LO,
        ST_RD_HI,
        ST_CAP,
        ST_EMIT,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE_OK,
        ST_FAIL
    } t_state;

endpackage

### rtl/core/mrrm_store.sv
// Data store of the region register map: one write port and one registered read port.
// Depends on mrrm_pkg for the word width.
module mrrm_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mrrm_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [mrrm_pkg::DATA_W-1:0] o_rdata
);
    import mrrm_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/modbus_region_register_map_unit.sv
// Top level of the Modbus region register map: region lookup, sequencer and result register.
// Depends on mrrm_pkg and mrrm_store.
//
// Usage: region descriptors are written through the cfg channel (index 0 to 3, always ready)
// while the block is idle. An access enters on the s_axis channel; tuser carries the command
// and address type, tdata the address, count, word index, write data and swap flag. Results
// leave on m_axis with ok in tuser, the data word in tdata and tlast on the final result.
// After reset the block sweeps the data store to zero, one word per cycle, and holds s_axis
// tready low until the sweep ends. An access is accepted while idle, tries one region at a
// time (1 to REGIONS) in the lookup loop and passes the bound check and setup states. A
// register read word is then read, captured and emitted; a bit read word is read low and
// high, captured and emitted; a bit write reads low and high, captures, then writes the low
// word (and the high word when the bits spill into the next word); a register write writes
// its word. Failures and empty accesses skip the store.
// Results pass through one output register; the sequencer waits there while the receiver
// stalls, and a new transaction is accepted while the last result still waits to be taken.
module modbus_region_register_map_unit #(
    parameter int REGIONS      = 4,
    parameter int REGION_WORDS = 256,
    parameter int MAX_WORDS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mrrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mrrm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // start_addr[15:0], count[26:16], word_index[32:27], write_data[48:33], byte_swap[49]
    input  logic [mrrm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[1:0], addr_type[3:2]
    input  logic [mrrm_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // read_data[15:0]
    output logic [mrrm_pkg::DATA_W-1:0]    o_m_axis_tdata,
    // ok[0]
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import mrrm_pkg::*;

    localparam int DEPTH = REGIONS * REGION_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(REGION_WORDS + 1);
    localparam int RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam logic [17:0] CAP_BITS = 18'(REGION_WORDS * 16);
    localparam logic [17:0] CAP_REGS = 18'(REGION_WORDS);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg [REGIONS];

    logic [1:0]         r_cmd, n_cmd;
    logic [1:0]         r_type, n_type;
    logic [15:0]        r_start, n_start;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [WIDX_W-1:0]  r_widx, n_widx;
    logic [DATA_W-1:0]  r_wdata, n_wdata;
    logic               r_swap, n_swap;
    logic [RIW-1:0]     r_ridx, n_ridx;
    logic [RIW-1:0]     r_hit, n_hit;
    logic [15:0]        r_base, n_base;
    logic [15:0]        r_offset, n_offset;
    logic [AW-1:0]      r_rbase, n_rbase;
    logic [PW-1:0]      r_pos, n_pos;
    logic [3:0]         r_shift, n_shift;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [COUNT_W-1:0] r_wleft, n_wleft;
    logic [DATA_W-1:0]  r_lo, n_lo;
    logic [DATA_W-1:0]  r_hi, n_hi;
    logic [AW-1:0]      r_clr, n_clr;

    logic               r_out_valid;
    logic               r_out_ok;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;

    logic               in_fire;
    logic               out_free;
    logic               is_bits;
    logic               is_write;
    logic               type_bad;
    logic [COUNT_W-1:0] words;
    logic [CFG_W-1:0]   cur_cfg;
    logic               region_hit;
    logic [15:0]        offset_calc;
    logic [17:0]        span_end;
    logic               bound_bad;
    logic [16:0]        el_calc;
    logic [COUNT_W-1:0] widx_bits;
    logic               hi_ok;
    logic [DATA_W-1:0]  mask16;
    logic [31:0]        window;
    logic [31:0]        mask32;
    logic [31:0]        data32;
    logic [31:0]        merged;
    logic               hi_needed;
    logic [AW-1:0]      addr_lo;
    logic [AW-1:0]      addr_hi;

    logic               load_out;
    logic               load_ok;
    logic [DATA_W-1:0]  load_data;
    logic               load_last;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign is_bits  = (r_cmd == CMD_RD_BITS) || (r_cmd == CMD_WR_BITS);
    assign is_write = (r_cmd == CMD_WR_BITS) || (r_cmd == CMD_WR_REGS);
    assign words    = is_bits ? COUNT_W'((12'(r_count) + 12'd15) >> 4) : r_count;
    assign widx_bits = COUNT_W'({r_widx, 4'b0000});

    // The lookup loop tests one region descriptor per cycle.
    assign cur_cfg    = r_cfg[r_ridx];
    assign region_hit = cur_cfg[31] && (cur_cfg[30:29] == r_type)
                        && (cur_cfg[15:0] <= r_start)
                        && ((17'(cur_cfg[15:0]) + 17'(cur_cfg[28:16]))
                            >= (17'(r_start) + 17'(r_count)));

    assign offset_calc = r_start - r_base;
    assign span_end    = 18'(offset_calc) + 18'(r_count);
    assign bound_bad   = (span_end > (is_bits ? CAP_BITS : CAP_REGS))
                         || (words > COUNT_W'(MAX_WORDS));

    assign el_calc = 17'(r_offset) + (is_write ? 17'(widx_bits) : 17'd0);

    assign hi_ok   = ((PW + 1)'(r_pos) + (PW + 1)'(1)) < (PW + 1)'(REGION_WORDS);
    assign addr_lo = r_rbase + AW'(r_pos);
    assign addr_hi = addr_lo + AW'(1);

    assign mask16    = (r_rem >= COUNT_W'(16)) ? 16'hFFFF
                       : 16'((17'd1 << r_rem[3:0]) - 17'd1);
    assign window    = {r_hi, r_lo} >> r_shift;
    assign mask32    = 32'(mask16) << r_shift;
    assign data32    = 32'(r_wdata) << r_shift;
    assign merged    = ({r_hi, r_lo} & ~mask32) | (data32 & mask32);
    assign hi_needed = (|mask32[31:16]) && hi_ok;

    always_comb begin
        type_bad = 1'b0;
        if (((n_cmd == CMD_RD_BITS) || (n_cmd == CMD_WR_BITS))
            && ((n_type == TYPE_HOLDING) || (n_type == TYPE_INPUT))) begin
            type_bad = 1'b1;
        end
        if (((n_cmd == CMD_RD_REGS) || (n_cmd == CMD_WR_REGS))
            && ((n_type == TYPE_COILS) || (n_type == TYPE_DISCRETE))) begin
            type_bad = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_type   = r_type;
        n_start  = r_start;
        n_count  = r_count;
        n_widx   = r_widx;
        n_wdata  = r_wdata;
        n_swap   = r_swap;
        n_ridx   = r_ridx;
        n_hit    = r_hit;
        n_base   = r_base;
        n_offset = r_offset;
        n_rbase  = r_rbase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_wleft  = r_wleft;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_clr    = r_clr;
        if (in_fire) begin
            n_cmd   = i_s_axis_tuser[CMD_LSB +: 2];
            n_type  = i_s_axis_tuser[TYPE_LSB +: 2];
            n_start = i_s_axis_tdata[START_LSB +: 16];
            n_count = i_s_axis_tdata[COUNT_LSB +: COUNT_W];
            n_widx  = i_s_axis_tdata[WIDX_LSB +: WIDX_W];
            n_wdata = i_s_axis_tdata[WDATA_LSB +: DATA_W];
            n_swap  = i_s_axis_tdata[SWAP_BIT];
        end
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_ridx = '0;
                if (in_fire) begin
                    n_state = type_bad ? ST_FAIL : ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (region_hit) begin
                    n_hit   = r_ridx;
                    n_base  = cur_cfg[15:0];
                    n_state = ST_BOUND;
                end else if (r_ridx == RIW'(REGIONS - 1)) begin
                    n_state = ST_FAIL;
                end else begin
                    n_ridx = r_ridx + RIW'(1);
                end
            end
            ST_BOUND: begin
                n_offset = offset_calc;
                n_rbase  = AW'(32'(r_hit) * REGION_WORDS);
                n_state  = bound_bad ? ST_FAIL : ST_SETUP;
            end
            ST_SETUP: begin
                n_wleft = words;
                if (is_bits) begin
                    n_pos   = PW'(el_calc >> 4);
                    n_shift = el_calc[3:0];
                    n_rem   = is_write ? (r_count - widx_bits) : r_count;
                end else begin
                    n_pos   = PW'(17'(r_offset) + (is_write ? 17'(r_widx) : 17'd0));
                    n_shift = 4'd0;
                    n_rem   = r_count;
                end
                unique case (r_cmd)
                    CMD_RD_BITS, CMD_RD_REGS: begin
                        n_state = (words == '0) ? ST_DONE_OK : ST_RD_LO;
                    end
                    CMD_WR_BITS: begin
                        n_state = (r_count > widx_bits) ? ST_RD_LO : ST_DONE_OK;
                    end
                    CMD_WR_REGS: begin
                        n_state = (r_count > COUNT_W'(r_widx)) ? ST_WR_LO : ST_DONE_OK;
                    end
                    default: begin
                        n_state = ST_FAIL;
                    end
                endcase
            end
            ST_RD_LO: begin
                n_state = is_bits ? ST_RD_HI : ST_CAP;
            end
            ST_RD_HI: begin
                n_lo    = mem_rdata;
                n_state = ST_CAP;
            end
            ST_CAP: begin
                if (is_bits) begin
                    n_hi = hi_ok ? mem_rdata : '0;
                end else begin
                    n_lo = mem_rdata;
                end
                n_state = is_write ? ST_WR_LO : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_wleft == COUNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = r_pos + PW'(1);
                        n_rem   = r_rem - COUNT_W'(16);
                        n_wleft = r_wleft - COUNT_W'(1);
                        n_state = ST_RD_LO;
                    end
                end
            end
            ST_WR_LO: begin
                n_state = (is_bits && hi_needed) ? ST_WR_HI : ST_DONE_OK;
            end
            ST_WR_HI: begin
                n_state = ST_DONE_OK;
            end
            ST_DONE_OK, ST_FAIL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        load_out  = 1'b0;
        load_ok   = 1'b0;
        load_data = '0;
        load_last = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = addr_lo;
        mem_wdata = '0;
        mem_raddr = addr_lo;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            ST_RD_HI: begin
                mem_raddr = hi_ok ? addr_hi : addr_lo;
            end
            ST_EMIT: begin
                load_out  = out_free;
                load_ok   = 1'b1;
                load_data = is_bits ? (window[15:0] & mask16) : r_lo;
                load_last = (r_wleft == COUNT_W'(1));
            end
            ST_WR_LO: begin
                mem_we = 1'b1;
                if (is_bits) begin
                    mem_wdata = merged[15:0];
                end else begin
                    mem_wdata = r_swap ? {r_wdata[7:0], r_wdata[15:8]} : r_wdata;
                end
            end
            ST_WR_HI: begin
                mem_we    = 1'b1;
                mem_waddr = addr_hi;
                mem_wdata = merged[31:16];
            end
            ST_DONE_OK: begin
                load_out = out_free;
                load_ok  = 1'b1;
            end
            ST_FAIL: begin
                load_out = out_free;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_type   <= n_type;
        r_start  <= n_start;
        r_count  <= n_count;
        r_widx   <= n_widx;
        r_wdata  <= n_wdata;
        r_swap   <= n_swap;
        r_ridx   <= n_ridx;
        r_hit    <= n_hit;
        r_base   <= n_base;
        r_offset <= n_offset;
        r_rbase  <= n_rbase;
        r_pos    <= n_pos;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_wleft  <= n_wleft;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < REGIONS; r++) begin
                r_cfg[r] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int r = 0; r < REGIONS; r++) begin
                if ((r < CFG_REGS) && (i_cfg_index == CFG_IDX_W'(r))) begin
                    r_cfg[r] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ok   <= load_ok;
            r_out_data <= load_data;
            r_out_last <= load_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tlast  = r_out_last;

    mrrm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
